// ----- design/utf8_stream_decoder_core_assert.svh -----
// Assertion macros used by the UTF-8 stream decoder core RTL.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define U8D_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8D_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/u8dec_pkg.sv -----
// Types and constants for the UTF-8 stream decoder.
package u8dec_pkg;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [7:0]  LEAD2_MIN      = 8'hC2;
  localparam logic [2:0]  LEAD4_MAX_LOW  = 3'd4;

  localparam logic [2:0]  LEN_NONE = 3'd0;
  localparam logic [2:0]  LEN_ONE  = 3'd1;
  localparam logic [2:0]  LEN_TWO  = 3'd2;
  localparam logic [2:0]  LEN_THREE = 3'd3;
  localparam logic [2:0]  LEN_FOUR = 3'd4;

  // Decoder state carried between bytes.
  typedef struct packed {
    logic [2:0]  expected_length;
    logic [1:0]  continuations_taken;
    logic [14:0] partial_value;
  } u8dec_state_t;

  // One result item.
  typedef struct packed {
    logic [20:0] code_point;
    logic        is_replacement;
    logic [2:0]  bytes_used;
  } u8dec_result_t;

  // Results caused by one byte: replacements around at most one main result.
  typedef struct packed {
    logic [2:0]    total;
    logic          main_valid;
    logic [1:0]    main_pos;
    u8dec_result_t main;
  } u8dec_burst_t;

endpackage

// ----- design/u8dec_step.sv -----
// Per-byte decode step: next state and result burst for one input byte.
module u8dec_step (
  input  u8dec_pkg::u8dec_state_t state,
  input  logic [7:0]              text_byte,
  input  logic                    end_of_text,
  output u8dec_pkg::u8dec_state_t state_next,
  output u8dec_pkg::u8dec_burst_t burst
);

  logic                    pending;
  logic                    is_cont;
  logic [2:0]              taken_inc;
  logic [20:0]             joined;
  logic [1:0]              reps_before;
  logic [1:0]              reps_after;
  logic                    main_valid;
  u8dec_pkg::u8dec_result_t main;
  u8dec_pkg::u8dec_state_t  mid;
  logic                    is_lead2;
  logic                    is_lead3;
  logic                    is_lead4;

  assign pending   = (state.expected_length != u8dec_pkg::LEN_NONE);
  assign is_cont   = (text_byte[7:6] == 2'b10);
  assign taken_inc = {1'b0, state.continuations_taken} + 3'd1;
  assign joined    = {state.partial_value, text_byte[5:0]};
  assign is_lead2  = (text_byte[7:5] == 3'b110) && (text_byte >= u8dec_pkg::LEAD2_MIN);
  assign is_lead3  = (text_byte[7:4] == 4'hE);
  assign is_lead4  = (text_byte[7:3] == 5'b11110) &&
                     (text_byte[2:0] <= u8dec_pkg::LEAD4_MAX_LOW);

  always_comb begin
    reps_before = 2'd0;
    main_valid  = 1'b0;
    main        = '{code_point: u8dec_pkg::REPLACEMENT_CP, is_replacement: 1'b1,
                    bytes_used: u8dec_pkg::LEN_ONE};
    mid         = state;

    if (pending && is_cont) begin
      if ((taken_inc + 3'd1) >= state.expected_length) begin
        main_valid = 1'b1;
        main       = '{code_point: joined, is_replacement: 1'b0,
                       bytes_used: state.expected_length};
        mid        = '0;
      end else begin
        mid.partial_value       = joined[14:0];
        mid.continuations_taken = taken_inc[1:0];
      end
    end else begin
      // Broken sequence: one replacement for the lead and each continuation.
      if (pending) begin
        reps_before = taken_inc[1:0];
      end
      mid = '0;
      priority if (!text_byte[7]) begin
        main_valid = 1'b1;
        main       = '{code_point: {13'd0, text_byte}, is_replacement: 1'b0,
                       bytes_used: u8dec_pkg::LEN_ONE};
      end else if (is_lead2) begin
        mid.expected_length = u8dec_pkg::LEN_TWO;
        mid.partial_value   = {10'd0, text_byte[4:0]};
      end else if (is_lead3) begin
        mid.expected_length = u8dec_pkg::LEN_THREE;
        mid.partial_value   = {11'd0, text_byte[3:0]};
      end else if (is_lead4) begin
        mid.expected_length = u8dec_pkg::LEN_FOUR;
        mid.partial_value   = {12'd0, text_byte[2:0]};
      end else begin
        main_valid = 1'b1;
      end
    end

    // End of text flushes whatever is still open.
    reps_after = 2'd0;
    state_next = mid;
    if (end_of_text) begin
      if (mid.expected_length != u8dec_pkg::LEN_NONE) begin
        reps_after = mid.continuations_taken + 2'd1;
      end
      state_next = '0;
    end

    burst.total      = {1'b0, reps_before} + {2'd0, main_valid} + {1'b0, reps_after};
    burst.main_valid = main_valid;
    burst.main_pos   = reps_before;
    burst.main       = main;
  end

endmodule

// ----- design/utf8_stream_decoder_core.sv -----
// UTF-8 stream decoder top level: byte stream in, code point stream out.
//
//  channel | dir | tdata (low bit up)            | tuser          | tlast
//  s_*     | in  | text_byte[7:0]                | -              | end_of_text
//  m_*     | out | code_point[20:0], bytes_used  | is_replacement | last_in_run
//
// Cycles: one byte per cycle when each byte yields at most one result
// and the output is not stalled. A byte with more results holds the input
// while the one-result-per-cycle output register drains the burst register.
// Results pass through the burst register, then the output register.
// Reset (rst, synchronous): decoder idle, burst and output registers empty.
// Output stall: burst register holds, input is refused once it is occupied.
`include "utf8_stream_decoder_core_assert.svh"

module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte[7:0]
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // code_point[20:0], bytes_used[23:21]
  output logic        m_tuser,   // is_replacement
  output logic        m_tlast    // last_in_run
);

  // Decoder state, updated on every accepted request.
  u8dec_pkg::u8dec_state_t  state;
  u8dec_pkg::u8dec_state_t  state_next;
  u8dec_pkg::u8dec_burst_t  step_burst;

  // Burst register: all results of one byte, emitted by position.
  logic                     burst_valid;
  logic [1:0]               burst_pos;
  u8dec_pkg::u8dec_burst_t  burst;

  // Output register.
  logic                     out_valid;
  u8dec_pkg::u8dec_result_t out_res;
  logic                     out_last;

  logic                     in_fire;
  logic                     out_free;
  logic                     burst_adv;
  logic                     pos_last;
  logic                     burst_done;
  u8dec_pkg::u8dec_result_t pick;

  u8dec_step u_step (
    .state       (state),
    .text_byte   (s_tdata),
    .end_of_text (s_tlast),
    .state_next  (state_next),
    .burst       (step_burst)
  );

  assign out_free   = !out_valid || m_tready;
  assign burst_adv  = burst_valid && out_free;
  assign pos_last   = (({1'b0, burst_pos} + 3'd1) == burst.total);
  assign burst_done = burst_adv && pos_last;
  assign s_tready   = !burst_valid || burst_done;
  assign in_fire    = s_tvalid && s_tready;

  // Main result sits at its slot; every other slot is a replacement.
  always_comb begin
    pick = '{code_point: u8dec_pkg::REPLACEMENT_CP, is_replacement: 1'b1,
             bytes_used: u8dec_pkg::LEN_ONE};
    if (burst.main_valid && (burst_pos == burst.main_pos)) begin
      pick = burst.main;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      burst_pos   <= 2'd0;
    end else if (in_fire && (step_burst.total != 3'd0)) begin
      burst_valid <= 1'b1;
      burst_pos   <= 2'd0;
    end else if (burst_done) begin
      burst_valid <= 1'b0;
      burst_pos   <= 2'd0;
    end else if (burst_adv) begin
      burst_pos <= burst_pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      burst <= step_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= burst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_adv) begin
      out_res  <= pick;
      out_last <= pos_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.bytes_used, out_res.code_point};
  assign m_tuser  = out_res.is_replacement;
  assign m_tlast  = out_last;

  `U8D_ASSERT_NOW(a_pending_shape, state.expected_length != u8dec_pkg::LEN_NONE,
    ({1'b0, state.continuations_taken} + 3'd1) < state.expected_length,
    "pending sequence has too many continuations")
  `U8D_ASSERT_NEXT(a_eot_flush, in_fire && s_tlast,
    state.expected_length == u8dec_pkg::LEN_NONE,
    "end of text left a sequence pending")
  `U8D_ASSERT_NOW(a_rep_fields, out_valid && out_res.is_replacement,
    (out_res.code_point == u8dec_pkg::REPLACEMENT_CP) &&
    (out_res.bytes_used == u8dec_pkg::LEN_ONE),
    "replacement result with wrong fields")
  `U8D_ASSERT_NEXT(a_burst_hold, burst_valid && !out_free,
    burst_valid && $stable(burst_pos),
    "burst moved while output stalled")
  `U8D_ASSERT_NOW(a_burst_pos, burst_valid,
    ({1'b0, burst_pos} < burst.total),
    "burst position past its result count")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the UTF-8 stream decoder core.
module tb;
  import u8dec_pkg::*;

  localparam logic [7:0] ASCII_MAX    = 8'h7F;
  localparam logic [7:0] CONT_MIN     = 8'h80;
  localparam logic [7:0] BAD_LEAD_MAX = 8'hC1;
  localparam logic [7:0] LEAD2_MAX    = 8'hDF;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD3_MAX    = 8'hEF;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] LEAD4_MAX    = 8'hF4;
  localparam logic [7:0] BAD_HIGH_MIN = 8'hF5;
  localparam logic [7:0] BYTE_MAX     = 8'hFF;

  localparam int RANDOM_BYTES = 246;
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // Directed bytes, end_of_text in bit 8.
  localparam logic [8:0] DIRECTED [24] = '{
    9'h000, 9'h07F,                    // ASCII extremes
    9'h0C2, 9'h080,                    // smallest 2-byte form
    9'h0EF, 9'h0BF, 9'h0BD,            // well-formed U+FFFD, not a replacement
    9'h0F4, 9'h0BF, 9'h0BF, 9'h0BF,    // largest 4-byte value
    9'h080, 9'h0C1, 9'h0F5, 9'h0FF,    // stray continuation and bad leads
    9'h0F0, 9'h080, 9'h080, 9'h041,    // sequence broken by ASCII
    9'h0DF, 9'h1E0,                    // broken by a lead, which is then flushed
    9'h0E1, 9'h180,                    // flush after one continuation
    9'h141                             // end of text on a plain byte
  };

  typedef struct packed {
    u8dec_result_t res;
    logic          last_in_run;
  } cp_item_t;

  // Predicts code points per accepted byte and checks them in order.
  class cp_checker;
    cp_item_t     expected_cps[$];
    u8dec_state_t st;
    int errors;
    int checked;
    int replacements;
    int eot_flushes;

    function new();
      st = '0;
      errors = 0;
      checked = 0;
      replacements = 0;
      eot_flushes = 0;
    endfunction

    function void push_cp(logic [20:0] cp, logic rep, logic [2:0] used);
      cp_item_t it;
      it.res.code_point = cp;
      it.res.is_replacement = rep;
      it.res.bytes_used = used;
      it.last_in_run = 1'b0;
      expected_cps.push_back(it);
    endfunction

    // One replacement for the lead and one per continuation taken.
    function int flush_seq();
      int n;
      n = 0;
      if (st.expected_length != LEN_NONE) begin
        for (int k = 0; k <= st.continuations_taken; k++) begin
          push_cp(REPLACEMENT_CP, 1'b1, LEN_ONE);
          n++;
        end
      end
      st = '0;
      return n;
    endfunction

    function int decode_fresh(logic [7:0] b);
      st = '0;
      if (b <= ASCII_MAX) begin
        push_cp({13'd0, b}, 1'b0, LEN_ONE);
        return 1;
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        st.expected_length = LEN_TWO;
        st.partial_value = {10'd0, b[4:0]};
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        st.expected_length = LEN_THREE;
        st.partial_value = {11'd0, b[3:0]};
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        st.expected_length = LEN_FOUR;
        st.partial_value = {12'd0, b[2:0]};
      end else begin
        push_cp(REPLACEMENT_CP, 1'b1, LEN_ONE);
        return 1;
      end
      return 0;
    endfunction

    function void decode_byte(logic [7:0] b, logic eot);
      logic [20:0] joined;
      int taken;
      int n;
      int flushed;
      n = 0;
      if (st.expected_length != LEN_NONE) begin
        if (b[7:6] == 2'b10) begin
          joined = {st.partial_value, b[5:0]};
          taken = st.continuations_taken + 1;
          if (taken + 1 >= st.expected_length) begin
            push_cp(joined, 1'b0, st.expected_length);
            n++;
            st = '0;
          end else begin
            st.partial_value = joined[14:0];
            st.continuations_taken = taken[1:0];
          end
        end else begin
          n += flush_seq();
          n += decode_fresh(b);
        end
      end else begin
        n += decode_fresh(b);
      end
      if (eot) begin
        flushed = flush_seq();
        if (flushed > 0) eot_flushes++;
        n += flushed;
      end
      if (n > 0) expected_cps[expected_cps.size() - 1].last_in_run = 1'b1;
    endfunction

    function void check_cp(logic [20:0] cp, logic rep, logic [2:0] used, logic last);
      cp_item_t want;
      if (expected_cps.size() == 0) begin
        $error("code point %h arrived with nothing expected", cp);
        errors++;
        return;
      end
      want = expected_cps.pop_front();
      checked++;
      if (want.res.is_replacement) replacements++;
      if (cp !== want.res.code_point) begin
        $error("code_point: expected %h, got %h", want.res.code_point, cp);
        errors++;
      end
      if (rep !== want.res.is_replacement) begin
        $error("is_replacement: expected %b, got %b", want.res.is_replacement, rep);
        errors++;
      end
      if (used !== want.res.bytes_used) begin
        $error("bytes_used: expected %0d, got %0d", want.res.bytes_used, used);
        errors++;
      end
      if (last !== want.last_in_run) begin
        $error("last_in_run: expected %b, got %b", want.last_in_run, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  cp_checker board;
  bit        steady;
  int        bytes_sent;
  int        cycles;
  int        recv_stall;

  utf8_stream_decoder_core uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly no gap, some short ones, a few long; none while steady.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit rare_eot();
    return $urandom_range(0, 24) == 0;
  endfunction

  // One request per byte; the predictor runs at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = eot;
    do @(posedge clk); while (!s_tready);
    board.decode_byte(b, eot);
    bytes_sent++;
  endtask

  // Lead of the given length plus conts continuation bytes.
  task automatic send_seq(input logic [2:0] len, input int conts, input bit eot_at_end);
    logic [7:0] lead;
    case (len)
      LEN_TWO:   lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
      LEN_THREE: lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
      default:   lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
    endcase
    send_byte(lead, (eot_at_end && conts == 0) ? 1'b1 : rare_eot());
    for (int k = 1; k <= conts; k++) begin
      send_byte(CONT_MIN | 8'($urandom_range(0, 63)),
                (eot_at_end && k == conts) ? 1'b1 : rare_eot());
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.expected_cps.size() > 0) @(posedge clk);
  endtask

  // Receiver: random stalls on the result side.
  initial begin
    recv_stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_stall > 0) begin
        m_tready = 1'b0;
        recv_stall--;
      end else begin
        m_tready = 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        board.check_cp(m_tdata[20:0], m_tuser, m_tdata[23:21], m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int r;
    logic [2:0] len;
    board = new();
    steady = 1'b0;
    bytes_sent = 0;
    cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_for_drain();

    // Mostly well-formed sequences, with truncation, noise and flushes mixed in.
    while (bytes_sent < $size(DIRECTED) + RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      len = LEN_TWO + 3'($urandom_range(0, 2));
      if (r < 28) send_byte(8'($urandom_range(0, ASCII_MAX)), rare_eot());
      else if (r < 44) send_seq(LEN_TWO, 1, 1'b0);
      else if (r < 60) send_seq(LEN_THREE, 2, 1'b0);
      else if (r < 72) send_seq(LEN_FOUR, 3, 1'b0);
      else if (r < 80) send_seq(len, $urandom_range(0, len - 2), 1'b0);
      else if (r < 86) send_seq(len, $urandom_range(0, len - 2), 1'b1);
      else if (r < 94) send_byte(8'($urandom_range(0, BYTE_MAX)), rare_eot());
      else if ($urandom_range(0, 1) == 1)
        send_byte(8'($urandom_range(CONT_MIN, BAD_LEAD_MAX)), rare_eot());
      else send_byte(8'($urandom_range(BAD_HIGH_MIN, BYTE_MAX)), rare_eot());
      if ($urandom_range(0, 59) == 0) wait_for_drain();
      if ($urandom_range(0, 29) == 0) steady = ~steady;
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d bytes; checked %0d code points, %0d of them replacements.",
             bytes_sent, board.checked, board.replacements);
    $display("End of text flushed a pending sequence %0d times.", board.eot_flushes);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
